[rtl/stdc_pkg.sv]
// shared constants, types and the tap weight function for the six-tap delay cluster
// used by every module of the block except the generic stdc_ram; depends on nothing
package stdc_pkg;

	// delay line geometry
	localparam int LINE_LEN  = 16384;
	localparam int ADDR_W    = $clog2(LINE_LEN);
	localparam int OFF_W     = ADDR_W + 1;
	localparam int TAP_COUNT = 6;
	localparam int TAP_W     = 3;

	// sample and register widths
	localparam int SAMPLE_W   = 24;
	localparam int BASE_W     = 11;
	localparam int DIFF_W     = 17;
	localparam int CFG_DATA_W = 17;
	localparam int CFG_IDX_W  = 1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIFFUSION  = 1'd1;

	// base delay limits and tap spacing
	localparam logic [BASE_W-1:0] BASE_MIN    = 11'd8;
	localparam logic [BASE_W-1:0] BASE_MAX    = 11'd1200;
	localparam int                STEP_W      = 7;
	localparam logic [STEP_W-1:0] STEP_MIN    = 7'd2;
	localparam int                DIV10_W     = 16;
	localparam logic [DIV10_W-1:0] DIV10_MUL  = 16'd52429;
	localparam int                DIV10_SHIFT = 19;

	// gain = floor((2^24 + 150 + 1344*diffusion) / 300), divide done as /4 then /75
	localparam logic [DIFF_W-1:0] DIFF_ONE      = 17'd65536;
	localparam int                NUM_W         = 27;
	localparam logic [NUM_W-1:0]  GAIN_NUM_BASE = 27'd16777366;
	localparam int                SLOPE_W       = 11;
	localparam logic [SLOPE_W-1:0] GAIN_SLOPE   = 11'd1344;
	localparam int                PRE_SHIFT     = 2;
	localparam int                RECIP_W       = 26;
	localparam logic [RECIP_W-1:0] GAIN_RECIP   = 26'd57266231;
	localparam int                RECIP_PROD_W  = NUM_W - PRE_SHIFT + RECIP_W;
	localparam int                GAIN_SHIFT    = 32;
	localparam int                GAIN_W        = 19;

	// accumulate and scale
	localparam int                SUM_W      = 28;
	localparam int                PROD_W     = 48;
	localparam int                OUT_SHIFT  = 24;
	localparam logic [PROD_W-1:0] ROUND_BIAS = 48'd8388608;
	localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 24'sh7FFFFF;
	localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 24'sh800000;

	typedef struct packed {
		logic [BASE_W-1:0] d0;
		logic [STEP_W-1:0] step;
		logic [GAIN_W-1:0] gain;
	} coef_t;

	typedef struct packed {
		logic             rd;
		logic             ok;
		logic             last;
		logic [TAP_W-1:0] tap;
	} tap_ctl_t;

	// weights 1,2,3,3,2,1
	function automatic logic [1:0] tap_weight(input logic [TAP_W-1:0] k);
		logic [1:0] w;
		case (k)
			3'd0: w = 2'd1;
			3'd1: w = 2'd2;
			3'd2: w = 2'd3;
			3'd3: w = 2'd3;
			3'd4: w = 2'd2;
			3'd5: w = 2'd1;
			default: w = 2'd0;
		endcase
		return w;
	endfunction

endpackage

[rtl/stdc_ram.sv]
// generic simple dual-port ram, one write and one registered read port
// depends on nothing
module stdc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/stdc_coef.sv]
// configuration registers and the derived tap spacing and output gain
// depends on stdc_pkg
module stdc_coef (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [stdc_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [stdc_pkg::CFG_DATA_W-1:0]    cfg_data,
	output stdc_pkg::coef_t                    coef
);
	import stdc_pkg::*;

	logic [BASE_W-1:0]          base_q;
	logic [DIFF_W-1:0]          diff_q;
	logic [BASE_W-1:0]          d0c;
	logic [BASE_W+DIV10_W-1:0]  q10;
	logic [STEP_W-1:0]          step_raw;
	logic [DIFF_W-1:0]          diffc;
	logic [DIFF_W+SLOPE_W-1:0]  slope_full;
	logic [NUM_W-1:0]           num_s1;
	logic [RECIP_PROD_W-1:0]    recip_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= 11'd11;
			diff_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_BASE_DELAY: base_q <= cfg_data[BASE_W-1:0];
				REG_DIFFUSION:  diff_q <= cfg_data[DIFF_W-1:0];
				default: ;
			endcase
		end
	end

	// clamped base delay and spacing max(2, d0/10)
	always_comb begin
		if (base_q < BASE_MIN) begin
			d0c = BASE_MIN;
		end else if (base_q > BASE_MAX) begin
			d0c = BASE_MAX;
		end else begin
			d0c = base_q;
		end
		q10      = d0c * DIV10_MUL;
		step_raw = q10[DIV10_SHIFT +: STEP_W];
	end

	// gain pipeline: the numerator is registered in num_s1, then the scaled product in recip_s2
	assign diffc      = (diff_q > DIFF_ONE) ? DIFF_ONE : diff_q;
	assign slope_full = diffc * GAIN_SLOPE;

	always_ff @(posedge clk) begin
		num_s1   <= GAIN_NUM_BASE + slope_full[NUM_W-1:0];
		recip_s2 <= num_s1[NUM_W-1:PRE_SHIFT] * GAIN_RECIP;
	end

	assign coef.d0   = d0c;
	assign coef.step = (step_raw < STEP_MIN) ? STEP_MIN : step_raw;
	assign coef.gain = recip_s2[GAIN_SHIFT +: GAIN_W];

endmodule

[rtl/stdc_seq.sv]
// item sequencer: write pointer, tap offsets and delay line addressing
// depends on stdc_pkg
module stdc_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        src_valid,
	output logic                        src_stall,
	input  stdc_pkg::coef_t             coef,
	input  logic                        loaded,
	output logic                        wr_en,
	output logic [stdc_pkg::ADDR_W-1:0] wr_addr,
	output logic                        rd_en,
	output logic [stdc_pkg::ADDR_W-1:0] rd_addr,
	output stdc_pkg::tap_ctl_t          ctl
);
	import stdc_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_TAP   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	localparam logic [OFF_W-1:0]  OFF_MAX  = OFF_W'(LINE_LEN - 3);
	localparam logic [OFF_W-1:0]  OFF_MIN  = OFF_W'(1);
	localparam logic [OFF_W-1:0]  LINE_OFF = OFF_W'(LINE_LEN);
	localparam logic [ADDR_W-1:0] PTR_LAST = ADDR_W'(LINE_LEN - 1);
	localparam logic [TAP_W-1:0]  TAP_LAST = TAP_W'(TAP_COUNT - 1);

	logic [1:0]        state_q;
	logic [TAP_W-1:0]  tap_q;
	logic [OFF_W-1:0]  off_q;
	logic [ADDR_W-1:0] wp_q;
	logic [ADDR_W-1:0] cur_q;
	logic              wrap_q;
	logic              accept;
	logic [OFF_W-1:0]  offc;
	logic [OFF_W-1:0]  cur_ext;
	logic [OFF_W-1:0]  raddr_full;

	assign src_stall = (state_q != ST_IDLE);
	assign accept    = src_valid && !src_stall;

	assign wr_en   = accept;
	assign wr_addr = wp_q;

	always_comb begin
		if (off_q > OFF_MAX) begin
			offc = OFF_MAX;
		end else if (off_q < OFF_MIN) begin
			offc = OFF_MIN;
		end else begin
			offc = off_q;
		end
		cur_ext = {1'b0, cur_q};
		if (offc > cur_ext) begin
			raddr_full = cur_ext + LINE_OFF - offc;
		end else begin
			raddr_full = cur_ext - offc;
		end
	end

	assign rd_en    = (state_q == ST_TAP);
	assign rd_addr  = raddr_full[ADDR_W-1:0];
	assign ctl.rd   = rd_en;
	// entries never written since reset read as zero
	assign ctl.ok   = wrap_q || (offc <= cur_ext);
	assign ctl.last = (tap_q == TAP_LAST);
	assign ctl.tap  = tap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tap_q   <= '0;
			off_q   <= '0;
			wp_q    <= '0;
			cur_q   <= '0;
			wrap_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cur_q   <= wp_q;
						wp_q    <= (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
						wrap_q  <= wrap_q || (wp_q == PTR_LAST);
						off_q   <= OFF_W'(coef.d0);
						tap_q   <= '0;
						state_q <= ST_TAP;
					end
				end
				ST_TAP: begin
					off_q <= off_q + OFF_W'(coef.step);
					tap_q <= tap_q + 1'b1;
					if (tap_q == TAP_LAST) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (loaded) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/stdc_mac.sv]
// weighted tap accumulator, gain multiply, rounding, saturation and output register
// depends on stdc_pkg
module stdc_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  stdc_pkg::tap_ctl_t                  ctl,
	input  logic [stdc_pkg::SAMPLE_W-1:0]       rd_data,
	input  logic [stdc_pkg::GAIN_W-1:0]         gain,
	output logic                                loaded,
	output logic                                dst_valid,
	input  logic                                dst_stall,
	output logic signed [stdc_pkg::SAMPLE_W-1:0] sample_out
);
	import stdc_pkg::*;

	tap_ctl_t                  ctl_s1;
	logic signed [SUM_W-1:0]   acc_q;
	logic                      done_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic                      prod_valid_q;
	logic                      dst_valid_q;
	logic signed [SUM_W-1:0]   ext;
	logic signed [SUM_W-1:0]   term;
	logic signed [GAIN_W:0]    gain_s;
	logic signed [PROD_W-1:0]  prod_w;
	logic [PROD_W-1:0]         rounded;
	logic signed [PROD_W-OUT_SHIFT-1:0] q_full;
	logic signed [SAMPLE_W-1:0] q_sat;

	always_comb begin
		ext = {{(SUM_W-SAMPLE_W){rd_data[SAMPLE_W-1]}}, rd_data};
		case (tap_weight(ctl_s1.tap))
			2'd1: term = ext;
			2'd2: term = ext <<< 1;
			2'd3: term = ext + (ext <<< 1);
			default: term = '0;
		endcase
		if (!ctl_s1.ok) begin
			term = '0;
		end
	end

	assign gain_s = $signed({1'b0, gain});
	assign prod_w = acc_q * gain_s;

	// round half up, floor shift, clamp to 24 bits
	always_comb begin
		rounded = prod_q + ROUND_BIAS;
		q_full  = rounded[PROD_W-1:OUT_SHIFT];
		if (q_full > PROD_W'(SAT_MAX)) begin
			q_sat = SAT_MAX;
		end else if (q_full < PROD_W'(SAT_MIN)) begin
			q_sat = SAT_MIN;
		end else begin
			q_sat = q_full[SAMPLE_W-1:0];
		end
	end

	assign loaded    = prod_valid_q && (!dst_valid_q || !dst_stall);
	assign dst_valid = dst_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1       <= '0;
			done_q       <= 1'b0;
			prod_valid_q <= 1'b0;
			dst_valid_q  <= 1'b0;
		end else begin
			ctl_s1 <= ctl;
			done_q <= ctl_s1.rd && ctl_s1.last;
			if (done_q) begin
				prod_valid_q <= 1'b1;
			end else if (loaded) begin
				prod_valid_q <= 1'b0;
			end
			if (loaded) begin
				dst_valid_q <= 1'b1;
			end else if (!dst_stall) begin
				dst_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.rd) begin
			acc_q <= ((ctl_s1.tap == '0) ? '0 : acc_q) + term;
		end
		if (done_q) begin
			prod_q <= prod_w;
		end
		if (loaded) begin
			sample_out <= q_sat;
		end
	end

endmodule

[rtl/six_tap_delay_cluster_top.sv]
// top level of the six-tap delay cluster: config, sequencer, delay line ram, accumulator
// depends on stdc_pkg, stdc_coef, stdc_seq, stdc_ram, stdc_mac
//
// usage
// - input channel src_valid/src_stall carries sample_in; a transfer happens at a rising
//   edge with src_valid high and src_stall low
// - output channel dst_valid/dst_stall carries sample_out, one result per input transfer
// - cfg_we/cfg_idx/cfg_data write base_delay (index 0) or diffusion (index 1) while idle
// - each transfer writes the sample into a 16384-entry delay line, then six taps are
//   read one per cycle through the single ram read port, weighted and summed
// - the sum is scaled by the diffusion gain, rounded and saturated to 24 bits
// - one item is in flight at a time: the next input is taken only after the previous
//   result has been loaded into the output register
// - each item passes through the six serial ram reads, then the gain multiply and rounding
// - the output register holds a finished result while dst_stall is high; the next
//   input can be taken meanwhile, its result waits until the register frees up
// - reset clears the write pointer and control state, sets base_delay 11 and diffusion 0;
//   delay line entries unwritten since reset read as zero via a wrap flag, no clearing pass
module six_tap_delay_cluster_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 src_valid,
	output logic                                 src_stall,
	input  logic signed [stdc_pkg::SAMPLE_W-1:0] sample_in,
	output logic                                 dst_valid,
	input  logic                                 dst_stall,
	output logic signed [stdc_pkg::SAMPLE_W-1:0] sample_out,
	input  logic                                 cfg_we,
	input  logic [stdc_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [stdc_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import stdc_pkg::*;

	coef_t             coef;
	tap_ctl_t          ctl;
	logic              loaded;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [SAMPLE_W-1:0] rd_data;

	// register file plus derived spacing and gain
	stdc_coef u_coef (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.coef     (coef)
	);

	// pointer, offsets and read addressing for one item at a time
	stdc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.coef      (coef),
		.loaded    (loaded),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.ctl       (ctl)
	);

	// delay line storage, written on transfer, read once per tap
	stdc_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (LINE_LEN)
	) u_line (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (sample_in),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// weighted sum, gain and output register
	stdc_mac u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.rd_data    (rd_data),
		.gain       (coef.gain),
		.loaded     (loaded),
		.dst_valid  (dst_valid),
		.dst_stall  (dst_stall),
		.sample_out (sample_out)
	);

endmodule

[tb/six_tap_delay_cluster_top_tb.sv]
// self-checking bench for six_tap_delay_cluster_top: random and directed samples,
// checked against a tap-mix predictor
// depends on stdc_pkg and six_tap_delay_cluster_top; no files or arguments needed
module six_tap_delay_cluster_top_tb;
	import stdc_pkg::*;

	localparam int LONG_HOLD = 120;    // cycles of forced receiver stall
	localparam int SETTLE    = 12;     // a little more than the block latency

	// clock, reset and block ports; the inputs driven here are known from time zero
	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       src_valid = 1'b0;
	logic                       src_stall;
	logic signed [SAMPLE_W-1:0] sample_in = '0;
	logic                       dst_valid;
	logic                       dst_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_idx   = '0;
	logic [CFG_DATA_W-1:0]      cfg_data  = '0;

	// predictor state: own copy of the delay line, write pointer and registers
	logic signed [SAMPLE_W-1:0] line_copy [LINE_LEN];
	logic [ADDR_W-1:0]          wr_ptr   = '0;
	logic [BASE_W-1:0]          base_reg = 11'd11;
	logic [DIFF_W-1:0]          diff_reg = '0;
	longint                     mix_weight [TAP_COUNT] = '{1, 2, 3, 3, 2, 1};

	// samples waiting to be sent and mixed outputs waiting to arrive
	logic signed [SAMPLE_W-1:0] pend_q [$];
	logic signed [SAMPLE_W-1:0] expected_mix_q [$];
	logic signed [SAMPLE_W-1:0] want_mix;

	// idle rates in percent, long-hold request counters, failure count
	int src_idle_pct = 38;
	int dst_idle_pct = 50;
	int hold_seq     = 0;
	int hold_ack     = 0;
	int hold_left    = 0;
	int err_cnt      = 0;

	six_tap_delay_cluster_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.src_valid  (src_valid),
		.src_stall  (src_stall),
		.sample_in  (sample_in),
		.dst_valid  (dst_valid),
		.dst_stall  (dst_stall),
		.sample_out (sample_out),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data)
	);

	always #5 clk = ~clk;

	// writes one sample into the line copy and returns the weighted, scaled tap sum
	function automatic logic signed [SAMPLE_W-1:0] tap_mix(input logic signed [SAMPLE_W-1:0] s);
		longint d0, spacing, diff, gain, acc, off, q;
		int     ri;
		d0 = base_reg;
		if (d0 < 8)
			d0 = 8;
		if (d0 > 1200)
			d0 = 1200;
		spacing = d0 / 10;
		if (spacing < 2)
			spacing = 2;
		// gain is round((0.08 + 0.42*diffusion) / 24) in Q0.24, diffusion capped at one
		diff = diff_reg;
		if (diff > 65536)
			diff = 65536;
		gain = (64'sd16777216 + 1344 * diff + 150) / 300;
		line_copy[wr_ptr] = s;
		acc = 0;
		for (int k = 0; k < TAP_COUNT; k++) begin
			off = d0 + k * spacing;
			if (off > LINE_LEN - 3)
				off = LINE_LEN - 3;
			if (off < 1)
				off = 1;
			ri = (int'(wr_ptr) + LINE_LEN - int'(off)) % LINE_LEN;
			acc += mix_weight[k] * longint'(line_copy[ri]);
		end
		wr_ptr = wr_ptr + 1'b1;
		// round half up, floor shift, then clamp to 24 bits
		q = (acc * gain + 64'sd8388608) >>> OUT_SHIFT;
		if (q > 64'sd8388607)
			q = 64'sd8388607;
		if (q < -64'sd8388608)
			q = -64'sd8388608;
		return q[SAMPLE_W-1:0];
	endfunction

	// random sample, leaning on the extremes now and then
	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(9))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return $urandom_range(1) ? 24'sh000000 : 24'shFFFFFF;
			3: return SAMPLE_W'($signed($urandom_range(64)) - 32);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		err_cnt++;
	endtask

	// input side: predict on each input transfer, then offer the next pending sample
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
			sample_in <= '0;
		end else begin
			if (src_valid && !src_stall)
				expected_mix_q.push_back(tap_mix(sample_in));
			// a stalled offer is held as it is
			if (!src_valid || !src_stall) begin
				if (pend_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					src_valid <= 1'b1;
					sample_in <= pend_q.pop_front();
				end else begin
					src_valid <= 1'b0;
				end
			end
		end
	end

	// output side: each output transfer is checked against the oldest expected mix
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			want_mix = '0;
		end else if (dst_valid && !dst_stall) begin
			if (expected_mix_q.size() == 0) begin
				report_mismatch($sformatf("unexpected output %0d", sample_out));
			end else begin
				want_mix = expected_mix_q.pop_front();
				if (sample_out !== want_mix)
					report_mismatch($sformatf("sample_out %0d, expected %0d",
						sample_out, want_mix));
			end
		end
	end

	// receiver stall: random at the current rate, or a long hold when one is requested
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_stall <= 1'b0;
			hold_left <= 0;
			hold_ack  <= 0;
		end else if (hold_ack != hold_seq) begin
			hold_ack  <= hold_seq;
			hold_left <= LONG_HOLD;
			dst_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			dst_stall <= 1'b1;
		end else begin
			dst_stall <= ($urandom_range(99) < dst_idle_pct);
		end
	end

	// wait until the sender is done and every expected mix has arrived, then let it settle
	task automatic drain_results();
		while (pend_q.size() != 0 || src_valid || expected_mix_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// both registers in back-to-back cycles; junk above the 11 base delay bits must be dropped
	task automatic write_regs(input logic [BASE_W-1:0] base_val,
			input logic [DIFF_W-1:0] diff_val);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= REG_BASE_DELAY;
		cfg_data <= {6'($urandom), base_val};
		@(posedge clk);
		cfg_idx  <= REG_DIFFUSION;
		cfg_data <= diff_val;
		@(posedge clk);
		cfg_we   <= 1'b0;
		base_reg = base_val;
		diff_reg = diff_val;
	endtask

	// one setting: drain, reprogram, pick idle rates, queue samples, maybe a long hold
	task automatic run_phase(input logic [BASE_W-1:0] base_val,
			input logic [DIFF_W-1:0] diff_val, input int n, input int mode, input bit hold);
		drain_results();
		write_regs(base_val, diff_val);
		case (mode)
			0: begin
				src_idle_pct = 38;
				dst_idle_pct = 50;
			end
			1: begin
				src_idle_pct = 50;
				dst_idle_pct = 38;
			end
			default: begin
				src_idle_pct = 0;
				dst_idle_pct = 0;
			end
		endcase
		@(negedge clk);
		repeat (n) pend_q.push_back(pick_sample());
		if (hold) begin
			// receiver holds off mid-stream while the sender keeps offering
			while (pend_q.size() > n / 2)
				@(posedge clk);
			@(posedge clk);
			hold_seq <= hold_seq + 1;
		end
	endtask

	initial begin
		foreach (line_copy[i])
			line_copy[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at reset settings: extremes and bit patterns, then runs of
		// full scale so the taps at offsets 11..21 see long stretches of each sign
		@(negedge clk);
		pend_q.push_back(24'sh7FFFFF);
		pend_q.push_back(24'sh800000);
		pend_q.push_back(24'sh000000);
		pend_q.push_back(24'shFFFFFF);
		pend_q.push_back(24'sh000001);
		pend_q.push_back(24'sh555555);
		pend_q.push_back(24'shAAAAAA);
		repeat (10) pend_q.push_back(24'sh7FFFFF);
		repeat (8) pend_q.push_back(24'sh800000);

		// base delay below, at and above its limits; diffusion at zero, one and past one
		run_phase(11'd0,    17'd131071, 150, 0, 1'b0);
		run_phase(11'd7,    17'd65537,  150, 0, 1'b0);
		run_phase(11'd8,    17'd65536,  160, 0, 1'b1);
		run_phase(11'd2047, 17'd0,      150, 1, 1'b0);
		run_phase(11'd1200, 17'd32768,  150, 1, 1'b0);
		run_phase(11'd1201, 17'd1,      160, 1, 1'b1);
		run_phase(BASE_W'($urandom), DIFF_W'($urandom), 170, 2, 1'b0);
		// 19 still spaces taps by two, 20 is the first where d0/10 reaches two
		run_phase(11'd19, DIFF_W'($urandom_range(65536)), 160, 2, 1'b1);
		run_phase(11'd20, DIFF_W'($urandom), 80, 2, 1'b0);
		run_phase(BASE_W'($urandom_range(1200, 8)), DIFF_W'($urandom_range(65536)), 150, 2, 1'b0);

		// bounded wait for the tail, then anything still expected is a failure
		while (pend_q.size() != 0 || src_valid)
			@(posedge clk);
		for (int i = 0; i < 2000 && expected_mix_q.size() != 0; i++)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (expected_mix_q.size() != 0)
			report_mismatch($sformatf("%0d expected outputs never arrived",
				expected_mix_q.size()));

		if (err_cnt == 0)
			$display("six_tap_delay_cluster_top_tb OK");
		else
			$display("six_tap_delay_cluster_top_tb NOT OK");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#5000000;
		$display("six_tap_delay_cluster_top_tb NOT OK");
		$finish;
	end

endmodule

[sim.f]
rtl/stdc_pkg.sv
rtl/stdc_ram.sv
rtl/stdc_coef.sv
rtl/stdc_seq.sv
rtl/stdc_mac.sv
rtl/six_tap_delay_cluster_top.sv
tb/six_tap_delay_cluster_top_tb.sv
